@@ hw/rtl/srcr_pkg.sv @@
`default_nettype none
// ============================================================================
// srcr_pkg
// Shared types, codes and constants of the chipset index/data register block
// with shadow-RAM and remap window decode.
// ============================================================================
package srcr_pkg;

    localparam int unsigned NumRegs = 12;
    localparam int unsigned RegIdxW = 4;

    localparam logic [7:0] IndexBaseReset = 8'h70;
    localparam logic [7:0] IndexAfterData = 8'hFF;
    localparam logic [7:0] ReadMiss       = 8'hFF;

    localparam logic [7:0] RegDefaults [NumRegs] = '{
        8'h1F, 8'h8F, 8'hF0, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h70, 8'h00, 8'h70, 8'h00, 8'h00
    };

    // register numbers read at fixed places
    localparam logic [RegIdxW-1:0] RegKeep   = 4'd0;
    localparam logic [RegIdxW-1:0] RegRom    = 4'd2;
    localparam logic [RegIdxW-1:0] RegSegHi  = 4'd3;
    localparam logic [RegIdxW-1:0] RegSegLo  = 4'd4;
    localparam logic [RegIdxW-1:0] RegRemap  = 4'd5;
    localparam logic [RegIdxW-1:0] RegMisc   = 4'd6;

    // opcodes
    localparam logic [1:0] OpIoWrite  = 2'd0;
    localparam logic [1:0] OpIoRead   = 2'd1;
    localparam logic [1:0] OpMemQuery = 2'd2;

    // io ports
    localparam logic PortIndex = 1'b0;
    localparam logic PortData  = 1'b1;

    // read source codes
    localparam logic [1:0] RsInternal = 2'd0;
    localparam logic [1:0] RsExtBus   = 2'd1;
    localparam logic [1:0] RsExtAny   = 2'd2;

    // write target codes
    localparam logic [1:0] WtDisabled = 2'd0;
    localparam logic [1:0] WtInternal = 2'd1;
    localparam logic [1:0] WtExtAny   = 2'd2;

    // claim kinds
    localparam logic [1:0] CkNone   = 2'd0;
    localparam logic [1:0] CkShadow = 2'd1;
    localparam logic [1:0] CkRemap  = 2'd2;

    localparam int unsigned AddrW = 26;

    // C0000-FFFFF is address bits 25:18 equal to 3
    localparam logic [7:0]       ShadowAreaHi = 8'd3;
    localparam logic [1:0]       BiosSeg64k   = 2'b11;
    localparam logic [2:0]       Win0Slot     = 3'd0;
    localparam logic [2:0]       Win1Slot     = 3'd1;
    localparam logic [AddrW-1:0] Win0Target   = 26'h00A0000;
    localparam logic [AddrW-1:0] Win1Target   = 26'h00D0000;

    typedef struct packed {
        logic [1:0]       opcode;
        logic             io_port;
        logic [7:0]       write_data;
        logic [AddrW-1:0] mem_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       read_data;
        logic [1:0]       read_source;
        logic [1:0]       write_target;
        logic [1:0]       claim_kind;
        logic [AddrW-1:0] mapped_address;
        logic [3:0]       isa_clock_divider;
        logic             reset_on_halt;
    } t_out_item;

    // register file view handed to the decoder
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] reg2;
        logic [7:0] reg3;
        logic [7:0] reg4;
        logic [7:0] reg5;
        logic [7:0] reg6_next;
    } t_reg_view;

    function automatic logic [3:0] isa_div(input logic [1:0] sel);
        logic [3:0] d;
        case (sel)
            2'd0: d = 4'd8;
            2'd1: d = 4'd6;
            2'd2: d = 4'd5;
            default: d = 4'd4;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/srcr_regs.sv @@
`default_nettype none
// ============================================================================
// srcr_regs
// Index register, index base and the twelve chip registers; performs the
// io part of a transaction and exposes the register view for decode.
// ============================================================================
module srcr_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_wdata,
    input  wire logic              i_step,
    input  wire srcr_pkg::t_in_item i_item,
    output srcr_pkg::t_reg_view    o_view
);

    logic [7:0] r_base;
    logic [7:0] r_index;
    logic [7:0] n_index;
    logic [7:0] r_regs [srcr_pkg::NumRegs];
    logic [7:0] n_regs [srcr_pkg::NumRegs];

    logic [7:0]                     offset;
    logic                           in_range;
    logic [srcr_pkg::RegIdxW-1:0]   idx;
    logic                           data_read;

    assign offset    = r_index - r_base;
    assign in_range  = ({24'd0, offset} < srcr_pkg::NumRegs);
    assign idx       = offset[srcr_pkg::RegIdxW-1:0];
    assign data_read = (i_item.opcode == srcr_pkg::OpIoRead) &&
                       (i_item.io_port == srcr_pkg::PortData);

    always_comb begin
        n_regs  = r_regs;
        n_index = r_index;
        case (i_item.opcode)
            srcr_pkg::OpIoWrite: begin
                if (i_item.io_port == srcr_pkg::PortIndex) begin
                    n_index = i_item.write_data;
                end else begin
                    if (in_range) begin
                        if (idx == srcr_pkg::RegKeep) begin
                            n_regs[idx] = {r_regs[idx][7:6], i_item.write_data[5:0]};
                        end else begin
                            n_regs[idx] = i_item.write_data;
                        end
                    end
                    n_index = srcr_pkg::IndexAfterData;
                end
            end
            srcr_pkg::OpIoRead: begin
                if (i_item.io_port == srcr_pkg::PortData) begin
                    n_index = srcr_pkg::IndexAfterData;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_view.read_data = (data_read && in_range) ? r_regs[idx] : srcr_pkg::ReadMiss;
        o_view.reg2      = r_regs[srcr_pkg::RegRom];
        o_view.reg3      = r_regs[srcr_pkg::RegSegHi];
        o_view.reg4      = r_regs[srcr_pkg::RegSegLo];
        o_view.reg5      = r_regs[srcr_pkg::RegRemap];
        o_view.reg6_next = n_regs[srcr_pkg::RegMisc];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= srcr_pkg::IndexBaseReset;
            r_index <= 8'd0;
            r_regs  <= srcr_pkg::RegDefaults;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (i_step) begin
                r_index <= n_index;
                r_regs  <= n_regs;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/srcr_decode.sv @@
`default_nettype none
// ============================================================================
// srcr_decode
// Shadow segment, BIOS area and remap window decode; assembles the result.
// ============================================================================
module srcr_decode (
    input  wire srcr_pkg::t_in_item  i_item,
    input  wire srcr_pkg::t_reg_view i_view,
    output srcr_pkg::t_out_item      o_result
);

    logic [srcr_pkg::AddrW-1:0] addr;
    logic [3:0] seg;
    logic [1:0] grp;
    logic       in_area;
    logic       bios;
    logic       seg_en;
    logic       seg_rom;
    logic       seg_mode;
    logic       copy;
    logic [1:0] ext;
    logic       high_shadow;
    logic [5:0] remap_mb;
    logic       remap_hit;
    logic       win0;
    logic       win1;
    logic [srcr_pkg::AddrW-1:0] offset;

    assign addr     = i_item.mem_address;
    assign seg      = addr[17:14];
    assign grp      = seg[3:2];
    assign in_area  = (addr[25:18] == srcr_pkg::ShadowAreaHi);
    assign bios     = in_area && (addr[17:16] == srcr_pkg::BiosSeg64k);
    assign seg_en   = (grp == 2'd0) ? i_view.reg4[{1'b1, seg[1:0]}]
                                    : i_view.reg3[seg[2:0] - 3'd4];
    assign seg_rom  = i_view.reg2[{1'b1, grp}];
    assign seg_mode = i_view.reg2[{1'b0, grp}];
    assign copy     = i_view.reg2[3];
    assign ext      = seg[3] ? srcr_pkg::RsExtAny : srcr_pkg::RsExtBus;

    assign high_shadow = copy
                       || ((|i_view.reg3[3:0]) && i_view.reg2[5])
                       || ((|i_view.reg3[7:4]) && i_view.reg2[6]);

    assign remap_mb  = i_view.reg5[5:0];
    assign remap_hit = (remap_mb != 6'd0) && (addr[25:20] == remap_mb);
    assign win0      = remap_hit && (addr[19:17] == srcr_pkg::Win0Slot);
    assign win1      = remap_hit && (addr[19:17] == srcr_pkg::Win1Slot) && !high_shadow;
    assign offset    = {9'd0, addr[16:0]};

    always_comb begin
        o_result.read_data         = i_view.read_data;
        o_result.read_source       = srcr_pkg::RsInternal;
        o_result.write_target      = srcr_pkg::WtDisabled;
        o_result.claim_kind        = srcr_pkg::CkNone;
        o_result.mapped_address    = addr;
        o_result.isa_clock_divider = srcr_pkg::isa_div(i_view.reg6_next[1:0]);
        o_result.reset_on_halt     = i_view.reg6_next[6];

        if (i_item.opcode == srcr_pkg::OpMemQuery) begin
            if (bios) begin
                o_result.claim_kind = srcr_pkg::CkShadow;
                if (i_view.reg2[7]) begin
                    o_result.read_source  = srcr_pkg::RsExtAny;
                    o_result.write_target = i_view.reg4[1] ? srcr_pkg::WtExtAny
                                                           : srcr_pkg::WtInternal;
                end
            end else if (in_area) begin
                o_result.claim_kind = srcr_pkg::CkShadow;
                if (copy) begin
                    o_result.read_source  = ext;
                    o_result.write_target = srcr_pkg::WtInternal;
                end else if (seg_en && seg_rom) begin
                    o_result.read_source  = srcr_pkg::RsInternal;
                    o_result.write_target = seg_mode ? srcr_pkg::WtDisabled
                                                     : srcr_pkg::WtInternal;
                end else begin
                    o_result.read_source  = ext;
                    o_result.write_target = srcr_pkg::WtDisabled;
                end
            end else if (win0) begin
                o_result.claim_kind     = srcr_pkg::CkRemap;
                o_result.read_source    = srcr_pkg::RsInternal;
                o_result.write_target   = srcr_pkg::WtInternal;
                o_result.mapped_address = srcr_pkg::Win0Target + offset;
            end else if (win1) begin
                o_result.claim_kind     = srcr_pkg::CkRemap;
                o_result.read_source    = srcr_pkg::RsInternal;
                o_result.write_target   = srcr_pkg::WtInternal;
                o_result.mapped_address = srcr_pkg::Win1Target + offset;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/shadow_ram_chipset_regs.sv @@
`default_nettype none
// ============================================================================
// shadow_ram_chipset_regs
// Chipset index/data register block with shadow-RAM and remap decode.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  i_in_item  (t_in_item)
//   out      output     o_out_valid/i_out_stall o_out_item (t_out_item)
//   cfg      input      i_cfg_we               i_cfg_wdata (index base)
//
// One transaction per cycle while the output is not stalled. A transaction is
// captured in the input register and its result is registered in the output
// register when it advances, set by the single register-access/decode pass between them.
// Reset restores the index base, the index and the chip register defaults.
// A stalled output holds; the input register still drains into the output
// register whenever that one is empty or being taken.
// ============================================================================
module shadow_ram_chipset_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire srcr_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output srcr_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_wdata
);

    logic                 r_s1_valid;
    srcr_pkg::t_in_item   r_s1_item;
    logic                 r_out_valid;
    srcr_pkg::t_out_item  r_out_item;

    logic                 advance;
    logic                 accept_in;
    srcr_pkg::t_reg_view  view;
    srcr_pkg::t_out_item  n_out_item;

    assign advance     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !advance;
    assign accept_in   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    srcr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (advance),
        .i_item      (r_s1_item),
        .o_view      (view)
    );

    srcr_decode u_decode (
        .i_item   (r_s1_item),
        .i_view   (view),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

    a_divider_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.isa_clock_divider == 4'd8 ||
                         o_out_item.isa_clock_divider == 4'd6 ||
                         o_out_item.isa_clock_divider == 4'd5 ||
                         o_out_item.isa_clock_divider == 4'd4))
        else $error("illegal bus clock divider");

    a_unclaimed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.claim_kind == srcr_pkg::CkNone) |->
        (o_out_item.read_source == srcr_pkg::RsInternal &&
         o_out_item.write_target == srcr_pkg::WtDisabled))
        else $error("unclaimed address carries a source or target");

    a_remap_internal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.claim_kind == srcr_pkg::CkRemap) |->
        (o_out_item.read_source == srcr_pkg::RsInternal &&
         o_out_item.write_target == srcr_pkg::WtInternal))
        else $error("remap window not internal RAM");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced transaction lost");

endmodule
`default_nettype wire

@@ test/shadow_ram_chipset_regs_test.sv @@
// ----------------------------------------------------------------------------
// shadow_ram_chipset_regs_test
// Self-checking bench for the chipset index/data register block. A directed
// table runs first, then random register sequences, address queries and noise
// under several index base settings. Each result is compared with its table
// value where known, else with an in-bench register-file and shadow/remap model.
// ----------------------------------------------------------------------------
module shadow_ram_chipset_regs_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  OpReserved  = 2'd3;
    localparam int unsigned BiosBase    = 'hF0000;
    localparam int unsigned BiosEnd     = 'h100000;
    localparam int unsigned SegBase     = 'hC0000;
    localparam int unsigned SegSize     = 'h4000;
    localparam int unsigned ExtAnyFrom  = 'hE0000;
    localparam int unsigned HighSeg     = 4;
    localparam int unsigned WinSize     = 'h20000;
    localparam int unsigned PhaseItems  = 230;
    localparam int unsigned DrainCycles = 8;

    typedef logic [srcr_pkg::AddrW-1:0] t_addr;

    typedef struct packed {
        srcr_pkg::t_in_item  item;
        logic                known;
        srcr_pkg::t_out_item want;
    } t_dir_row;

    localparam t_dir_row DirRows [25] = '{
        '{'{srcr_pkg::OpIoRead, srcr_pkg::PortIndex, 8'h00, 26'h0000000}, 1'b1,
          '{8'hFF, srcr_pkg::RsInternal, srcr_pkg::WtDisabled, srcr_pkg::CkNone,
            26'h0000000, 4'd8, 1'b0}},
        '{'{srcr_pkg::OpIoRead, srcr_pkg::PortData, 8'hFF, 26'h3FFFFFF}, 1'b1,
          '{8'hFF, srcr_pkg::RsInternal, srcr_pkg::WtDisabled, srcr_pkg::CkNone,
            26'h3FFFFFF, 4'd8, 1'b0}},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortIndex, 8'h70, 26'h0000000}, 1'b1,
          '{8'hFF, srcr_pkg::RsInternal, srcr_pkg::WtDisabled, srcr_pkg::CkNone,
            26'h0000000, 4'd8, 1'b0}},
        '{'{srcr_pkg::OpIoRead, srcr_pkg::PortData, 8'h00, 26'h0000000}, 1'b1,
          '{8'h1F, srcr_pkg::RsInternal, srcr_pkg::WtDisabled, srcr_pkg::CkNone,
            26'h0000000, 4'd8, 1'b0}},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortIndex, 8'h70, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortData, 8'hFF, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortIndex, 8'h70, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoRead, srcr_pkg::PortData, 8'h00, 26'h0000000}, 1'b1,
          '{8'h3F, srcr_pkg::RsInternal, srcr_pkg::WtDisabled, srcr_pkg::CkNone,
            26'h0000000, 4'd8, 1'b0}},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortIndex, 8'h76, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortData, 8'hC3, 26'h0000000}, 1'b1,
          '{8'hFF, srcr_pkg::RsInternal, srcr_pkg::WtDisabled, srcr_pkg::CkNone,
            26'h0000000, 4'd4, 1'b1}},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortIndex, 8'h75, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortData, 8'h01, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpMemQuery, srcr_pkg::PortIndex, 8'h00, 26'h0100000}, 1'b1,
          '{8'hFF, srcr_pkg::RsInternal, srcr_pkg::WtInternal, srcr_pkg::CkRemap,
            26'h00A0000, 4'd4, 1'b1}},
        '{'{srcr_pkg::OpMemQuery, srcr_pkg::PortData, 8'hFF, 26'h013FFFF}, 1'b0, '0},
        '{'{srcr_pkg::OpMemQuery, srcr_pkg::PortIndex, 8'h00, 26'h00F0000}, 1'b0, '0},
        '{'{srcr_pkg::OpMemQuery, srcr_pkg::PortIndex, 8'h00, 26'h00FFFFF}, 1'b0, '0},
        '{'{srcr_pkg::OpMemQuery, srcr_pkg::PortIndex, 8'h00, 26'h00C0000}, 1'b0, '0},
        '{'{srcr_pkg::OpMemQuery, srcr_pkg::PortIndex, 8'h00, 26'h0000000}, 1'b1,
          '{8'hFF, srcr_pkg::RsInternal, srcr_pkg::WtDisabled, srcr_pkg::CkNone,
            26'h0000000, 4'd4, 1'b1}},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortIndex, 8'h7C, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortData, 8'hAA, 26'h0000000}, 1'b0, '0},
        '{'{OpReserved, srcr_pkg::PortData, 8'hFF, 26'h3FFFFFF}, 1'b1,
          '{8'hFF, srcr_pkg::RsInternal, srcr_pkg::WtDisabled, srcr_pkg::CkNone,
            26'h3FFFFFF, 4'd4, 1'b1}},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortIndex, 8'h7B, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortData, 8'h55, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoWrite, srcr_pkg::PortIndex, 8'h7B, 26'h0000000}, 1'b0, '0},
        '{'{srcr_pkg::OpIoRead, srcr_pkg::PortData, 8'h00, 26'h0000000}, 1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    srcr_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_stall;
    srcr_pkg::t_out_item out_item;
    logic                cfg_we;
    logic [7:0]          cfg_wdata;

    logic [7:0] index_base;
    logic [7:0] index_reg;
    logic [7:0] chip_regs [srcr_pkg::NumRegs];
    srcr_pkg::t_out_item results_due [$];
    logic       quiet;
    int unsigned errors;
    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned n_bases;

    shadow_ram_chipset_regs dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic seg_shadowed(input int unsigned seg);
        logic en;
        en = (seg >= 4) ? chip_regs[srcr_pkg::RegSegHi][seg - 4]
                        : chip_regs[srcr_pkg::RegSegLo][seg + 4];
        return en && chip_regs[srcr_pkg::RegRom][(seg >> 2) + 4];
    endfunction

    function automatic srcr_pkg::t_out_item predict_access(input srcr_pkg::t_in_item it);
        srcr_pkg::t_out_item o;
        logic [7:0]  sel;
        int unsigned a;
        int unsigned r;
        int unsigned seg;
        int unsigned i;
        logic [1:0]  ext;
        logic        high_shadow;
        o                = '0;
        o.read_data      = srcr_pkg::ReadMiss;
        o.mapped_address = it.mem_address;
        sel = index_reg - index_base;
        a   = it.mem_address;
        r   = {chip_regs[srcr_pkg::RegRemap][5:0], 20'h0};
        case (it.opcode)
            srcr_pkg::OpIoWrite: begin
                if (it.io_port == srcr_pkg::PortIndex) begin
                    index_reg = it.write_data;
                end else begin
                    if (sel < srcr_pkg::NumRegs) begin
                        if (sel == srcr_pkg::RegKeep)
                            chip_regs[sel] = {chip_regs[sel][7:6], it.write_data[5:0]};
                        else
                            chip_regs[sel] = it.write_data;
                    end
                    index_reg = srcr_pkg::IndexAfterData;
                end
            end
            srcr_pkg::OpIoRead: begin
                if (it.io_port == srcr_pkg::PortData) begin
                    if (sel < srcr_pkg::NumRegs)
                        o.read_data = chip_regs[sel];
                    index_reg = srcr_pkg::IndexAfterData;
                end
            end
            srcr_pkg::OpMemQuery: begin
                if (a >= BiosBase && a < BiosEnd) begin
                    o.claim_kind = srcr_pkg::CkShadow;
                    if (chip_regs[srcr_pkg::RegRom][7]) begin
                        o.read_source  = srcr_pkg::RsExtAny;
                        o.write_target = chip_regs[srcr_pkg::RegSegLo][1] ? srcr_pkg::WtExtAny
                                                                          : srcr_pkg::WtInternal;
                    end
                end else if (a >= SegBase && a < BiosBase) begin
                    seg = (a - SegBase) / SegSize;
                    ext = (SegBase + seg * SegSize >= ExtAnyFrom) ? srcr_pkg::RsExtAny
                                                                  : srcr_pkg::RsExtBus;
                    o.claim_kind = srcr_pkg::CkShadow;
                    if (chip_regs[srcr_pkg::RegRom][3]) begin
                        o.read_source  = ext;
                        o.write_target = srcr_pkg::WtInternal;
                    end else if (seg_shadowed(seg)) begin
                        o.read_source  = srcr_pkg::RsInternal;
                        o.write_target = chip_regs[srcr_pkg::RegRom][seg >> 2]
                                       ? srcr_pkg::WtDisabled : srcr_pkg::WtInternal;
                    end else begin
                        o.read_source  = ext;
                        o.write_target = srcr_pkg::WtDisabled;
                    end
                end else if (r != 0) begin
                    high_shadow = chip_regs[srcr_pkg::RegRom][3];
                    for (i = HighSeg; i < srcr_pkg::NumRegs; i++)
                        high_shadow = high_shadow | seg_shadowed(i);
                    if (a >= r && a < r + WinSize) begin
                        o.claim_kind     = srcr_pkg::CkRemap;
                        o.read_source    = srcr_pkg::RsInternal;
                        o.write_target   = srcr_pkg::WtInternal;
                        o.mapped_address = t_addr'(a - r + srcr_pkg::Win0Target);
                    end else if (!high_shadow && a >= r + WinSize && a < r + 2 * WinSize) begin
                        o.claim_kind     = srcr_pkg::CkRemap;
                        o.read_source    = srcr_pkg::RsInternal;
                        o.write_target   = srcr_pkg::WtInternal;
                        o.mapped_address = t_addr'(a - r - WinSize + srcr_pkg::Win1Target);
                    end
                end
            end
            default: ;
        endcase
        case (chip_regs[srcr_pkg::RegMisc][1:0])
            2'd0: o.isa_clock_divider = 4'd8;
            2'd1: o.isa_clock_divider = 4'd6;
            2'd2: o.isa_clock_divider = 4'd5;
            default: o.isa_clock_divider = 4'd4;
        endcase
        o.reset_on_halt = chip_regs[srcr_pkg::RegMisc][6];
        return o;
    endfunction

    function automatic srcr_pkg::t_in_item rand_in();
        srcr_pkg::t_in_item it;
        it.opcode      = 2'($urandom);
        it.io_port     = 1'($urandom);
        it.write_data  = 8'($urandom);
        it.mem_address = t_addr'($urandom);
        return it;
    endfunction

    function automatic void field_check(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic send(input srcr_pkg::t_in_item it, input logic known,
                        input srcr_pkg::t_out_item want);
        int unsigned gap;
        srcr_pkg::t_out_item pred;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pred = predict_access(it);
        results_due.push_back(known ? want : pred);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic set_index_base(input logic [7:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        index_base = v;
        n_bases++;
    endtask

    task automatic register_access();
        logic [7:0] k;
        srcr_pkg::t_in_item it;
        k = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                        : 8'($urandom_range(0, srcr_pkg::NumRegs - 1));
        it            = rand_in();
        it.opcode     = srcr_pkg::OpIoWrite;
        it.io_port    = srcr_pkg::PortIndex;
        it.write_data = index_base + k;
        send(it, 1'b0, '0);
        if ($urandom_range(0, 7) == 0) begin
            it         = rand_in();
            it.opcode  = srcr_pkg::OpIoRead;
            it.io_port = srcr_pkg::PortIndex;
            send(it, 1'b0, '0);
        end
        it         = rand_in();
        it.io_port = srcr_pkg::PortData;
        it.opcode  = ($urandom_range(0, 2) == 0) ? srcr_pkg::OpIoRead : srcr_pkg::OpIoWrite;
        if (k == srcr_pkg::RegRemap && $urandom_range(0, 3) == 0)
            it.write_data[5:0] = '0;
        send(it, 1'b0, '0);
    endtask

    task automatic address_query();
        srcr_pkg::t_in_item it;
        int unsigned a;
        int unsigned r;
        r = {chip_regs[srcr_pkg::RegRemap][5:0], 20'h0};
        case ($urandom_range(0, 7))
            0: a = BiosBase + $urandom_range(0, 'hFFFF);
            1: a = SegBase + $urandom_range(0, BiosBase - SegBase - 1);
            2: a = SegBase + $urandom_range(0, srcr_pkg::NumRegs) * SegSize
                   - $urandom_range(0, 1);
            3, 4: a = r + $urandom_range(0, 2 * WinSize - 1);
            5: a = $urandom_range(0, 1) ? r - 1 : r + 2 * WinSize;
            6: a = $urandom;
            default: a = $urandom_range(0, BiosEnd - 1);
        endcase
        it             = rand_in();
        it.opcode      = srcr_pkg::OpMemQuery;
        it.mem_address = t_addr'(a);
        send(it, 1'b0, '0);
    endtask

    initial begin
        out_stall <= 1'b0;
        forever begin
            int unsigned gap;
            gap = quiet ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk) begin : check_results
        srcr_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected transaction on the result channel");
                errors++;
            end else begin
                want = results_due.pop_front();
                field_check("read_data", want.read_data, out_item.read_data);
                field_check("read_source", want.read_source, out_item.read_source);
                field_check("write_target", want.write_target, out_item.write_target);
                field_check("claim_kind", want.claim_kind, out_item.claim_kind);
                field_check("mapped_address", want.mapped_address, out_item.mapped_address);
                field_check("isa_clock_divider", want.isa_clock_divider,
                            out_item.isa_clock_divider);
                field_check("reset_on_halt", want.reset_on_halt, out_item.reset_on_halt);
                n_checked++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("shadow_ram_chipset_regs verification failed");
        $finish;
    end

    initial begin
        logic [7:0]  bases [5];
        int unsigned phase_end;
        int unsigned pick;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        quiet      = 1'b0;
        errors     = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_bases    = 1;
        index_base = srcr_pkg::IndexBaseReset;
        index_reg  = '0;
        chip_regs  = srcr_pkg::RegDefaults;
        bases      = '{8'h30, 8'h00, 8'hFF, 8'($urandom), 8'h70};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DirRows[i])
            send(DirRows[i].item, DirRows[i].known, DirRows[i].want);

        foreach (bases[p]) begin
            set_index_base(bases[p]);
            phase_end = n_sent + PhaseItems;
            while (n_sent < phase_end) begin
                if ($urandom_range(0, 31) == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    register_access();
                else if (pick < 17)
                    address_query();
                else
                    send(rand_in(), 1'b0, '0);
            end
            quiet = 1'b0;
        end

        wait_drained();
        $display("%0d transactions sent under %0d index base settings, %0d results compared",
                 n_sent, n_bases, n_checked);
        if (errors == 0)
            $display("shadow_ram_chipset_regs verification clean");
        else
            $display("shadow_ram_chipset_regs verification failed");
        $finish;
    end

endmodule
